[rtl/core/itda_pkg.sv]
// Shared types, constants and helpers of the integer to decimal ASCII unit.
// No dependencies; imported by every module of the unit.
package itda_pkg;

  // Widths of the stream fields.
  localparam int VALUE_W      = 64;
  localparam int WCODE_W      = 2;
  localparam int CHAR_W       = 7;
  localparam int IN_TUSER_W   = 1 + WCODE_W;
  localparam int OUT_TDATA_W  = 8;

  // Default for the widest operand the unit converts.
  localparam int MAX_VALUE_WIDTH_DEF = 64;

  // Double-dabble work per cycle and BCD digit size.
  localparam int BITS_PER_STEP = 4;
  localparam int BCD_W         = 4;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  // Operand width codes.
  localparam logic [WCODE_W-1:0] WCODE_8  = 2'd0;
  localparam logic [WCODE_W-1:0] WCODE_16 = 2'd1;
  localparam logic [WCODE_W-1:0] WCODE_32 = 2'd2;
  localparam logic [WCODE_W-1:0] WCODE_64 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGIT
  } itda_state_t;

  // One character headed for the output register.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } itda_char_t;

  // Operand width in bits selected by a width code.
  function automatic int width_of(logic [WCODE_W-1:0] code);
    int w;
    case (code)
      WCODE_8:  w = 8;
      WCODE_16: w = 16;
      WCODE_32: w = 32;
      WCODE_64: w = 64;
      default:  w = 64;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/itda_bcd_step.sv]
// Shared double-dabble unit: shifts four binary bits into a BCD accumulator.
// Depends on itda_pkg.
module itda_bcd_step #(
  parameter int NDIG = 20
) (
  input  logic [4*NDIG-1:0]                  bcd_i,
  input  logic [itda_pkg::BITS_PER_STEP-1:0] bits_i,  // MSB enters first
  output logic [4*NDIG-1:0]                  bcd_o
);
  import itda_pkg::*;

  always_comb begin
    logic [4*NDIG-1:0] t;
    t = bcd_i;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      // add 3 to every digit of 5 or more, then shift one bit in
      for (int d = 0; d < NDIG; d++) begin
        if (t[d*BCD_W +: BCD_W] >= 4'd5) begin
          t[d*BCD_W +: BCD_W] = t[d*BCD_W +: BCD_W] + 4'd3;
        end
      end
      t = {t[4*NDIG-2:0], bits_i[BITS_PER_STEP-1-s]};
    end
    bcd_o = t;
  end

endmodule

[rtl/core/itda_out_reg.sv]
// Output register of the result stream: holds one character until taken.
// Depends on itda_pkg.
module itda_out_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  itda_pkg::itda_char_t               char_in,
  output logic                               can_load,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [itda_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);
  import itda_pkg::*;

  logic       valid_r;
  itda_char_t data_r;

  // accept a new character when empty or when the held one leaves now
  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= char_in;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAR_W){1'b0}}, data_r.char_code};
  assign out_tlast  = data_r.last;

endmodule

[rtl/core/integer_to_decimal_ascii_unit.sv]
// Integer to decimal ASCII converter, top level.
// Depends on itda_pkg, itda_bcd_step and itda_out_reg.
//
// Usage:
//   Input stream: in_tdata carries the 64 raw value bits; in_tuser carries
//   is_signed (bit 0) and width_code (bits 2:1, 0=8, 1=16, 2=32, 3=64 bits).
//   Only the low operand-width bits of the value count.
//   Output stream: one ASCII character per transfer, most significant digit
//   first, a leading minus for negative signed values; out_tlast marks the
//   last character of each number. Zero gives the single character '0'.
//
//   Timing: the number is converted by a shared double-dabble unit that
//   takes four bits per cycle, working through the operand's width in groups
//   of four bits. A separate state then locates the leading digit, and the
//   characters follow at one per cycle while out_tready stays high.
//   in_tready is high only while the unit is idle; one number is in work
//   at a time.
//   Reset clears the sequencer and the output register; nothing else needs
//   clearing. When the receiver drops out_tready the current character holds
//   in the output register and the sequencer waits.
module integer_to_decimal_ascii_unit #(
  parameter int MAX_VALUE_WIDTH = itda_pkg::MAX_VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [itda_pkg::VALUE_W-1:0]       in_tdata,   // value[63:0]
  input  logic [itda_pkg::IN_TUSER_W-1:0]    in_tuser,   // is_signed, width_code[1:0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [itda_pkg::OUT_TDATA_W-1:0]   out_tdata,  // char_code[6:0], zero pad
  output logic                               out_tlast   // last
);
  import itda_pkg::*;

  localparam int MW        = MAX_VALUE_WIDTH;
  // decimal digits of the largest MW-bit unsigned value (log10(2) ~ 0.30103)
  localparam int NDIG      = (MW * 30103) / 100000 + 1;
  localparam int STEPS_MAX = (MW + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SW        = STEPS_MAX * BITS_PER_STEP;
  localparam int EW_W      = $clog2(MW + 1);
  localparam int SIDX_W    = $clog2(MW);
  localparam int STEP_W    = $clog2(STEPS_MAX + 1);
  localparam int DIDX_W    = $clog2(NDIG);

  // sequencer and datapath registers
  itda_state_t         state_r, state_nxt;
  logic [SW-1:0]       shreg_r, shreg_nxt;    // binary bits still to shift in
  logic [4*NDIG-1:0]   bcd_r, bcd_nxt;        // BCD accumulator
  logic [STEP_W-1:0]   step_r, step_nxt;      // conversion steps left
  logic                neg_r, neg_nxt;
  logic [DIDX_W-1:0]   idx_r, idx_nxt;        // digit being sent

  // input decode
  logic                in_signed;
  logic [WCODE_W-1:0]  in_wcode;
  logic [EW_W-1:0]     w_eff;
  logic [MW-1:0]       mask;
  logic [MW-1:0]       v;
  logic [SIDX_W-1:0]   sidx;
  logic                in_neg;
  logic [MW-1:0]       mag;
  logic [STEP_W-1:0]   nsteps;
  logic [SW-1:0]       shreg_load;

  // shared unit and output side
  logic [4*NDIG-1:0]   bcd_step;
  logic [DIDX_W-1:0]   top_idx;
  logic                can_load;
  logic                out_load;
  itda_char_t          out_char;

  assign in_signed = in_tuser[0];
  assign in_wcode  = in_tuser[IN_TUSER_W-1:1];

  always_comb begin
    int tw;
    tw = width_of(in_wcode);
    // clamp operands wider than the unit supports
    w_eff = (tw > MW) ? EW_W'(MW) : EW_W'(tw);
    for (int i = 0; i < MW; i++) begin
      mask[i] = (i < int'(w_eff));
    end
    v      = in_tdata[MW-1:0] & mask;
    sidx   = SIDX_W'(w_eff - EW_W'(1));
    in_neg = in_signed && v[sidx];
    // two's complement magnitude; the most negative value maps to 2^(w-1)
    mag    = in_neg ? ((~v + MW'(1)) & mask) : v;
    nsteps = STEP_W'((int'(w_eff) + BITS_PER_STEP - 1) >> 2);
    // align so the last step consumes the magnitude's lowest bit
    shreg_load = SW'(mag) << (SW - BITS_PER_STEP * int'(nsteps));
  end

  itda_bcd_step #(
    .NDIG (NDIG)
  ) u_bcd_step (
    .bcd_i  (bcd_r),
    .bits_i (shreg_r[SW-1 -: BITS_PER_STEP]),
    .bcd_o  (bcd_step)
  );

  // highest nonzero digit; zero reads as one digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*BCD_W +: BCD_W] != '0) begin
        top_idx = DIDX_W'(d);
      end
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    shreg_nxt = shreg_r;
    bcd_nxt   = bcd_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    idx_nxt   = idx_r;
    out_load  = 1'b0;
    out_char.char_code = CHAR_MINUS;
    out_char.last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          shreg_nxt = shreg_load;
          bcd_nxt   = '0;
          step_nxt  = nsteps;
          neg_nxt   = in_neg;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // advance the shared unit by one group of bits
        bcd_nxt   = bcd_step;
        shreg_nxt = shreg_r << BITS_PER_STEP;
        step_nxt  = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        idx_nxt   = top_idx;
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (can_load) begin
          out_load  = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_char.char_code = CHAR_ZERO + {3'b000, bcd_r[idx_r*BCD_W +: BCD_W]};
        out_char.last      = (idx_r == '0);
        if (can_load) begin
          out_load = 1'b1;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - DIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    bcd_r   <= bcd_nxt;
    step_r  <= step_nxt;
    neg_r   <= neg_nxt;
    idx_r   <= idx_nxt;
  end

  itda_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .char_in    (out_char),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
